@@ rtl/bmsw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_pkg
// Shared constants, types and helpers for the binary morphology window core.
// ----------------------------------------------------------------------------
package bmsw_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_MASK   = 15;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int STORE_W = MAX_MASK - 1;
   localparam int MASK_W  = 4;
   localparam int DIM_W   = 11;
   localparam int PIX_W   = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_SIZE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   localparam logic [PIX_W-1:0] FG_THRESHOLD = 8'd127;
   localparam logic [PIX_W-1:0] PIX_ON       = 8'd255;
   localparam logic [PIX_W-1:0] PIX_OFF      = 8'd0;

   localparam logic [MASK_W-1:0] MASK_RESET   = 4'd3;
   localparam logic [DIM_W-1:0]  WIDTH_RESET  = 11'd512;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd512;

   typedef struct packed {
      logic             fg;
      logic             emit;
      logic             last;
      logic [COL_W-1:0] col;
   } stage_type;

   // low n bits set, n in 0..MAX_MASK
   function automatic logic [MAX_MASK-1:0] low_ones(input logic [MASK_W-1:0] n);
      logic [MAX_MASK-1:0] m;
      for (int i = 0; i < MAX_MASK; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   // clamp a dimension to 1..max and return it minus one
   function automatic logic [COL_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
      logic [DIM_W-1:0] c;
      if (v == '0) begin
         c = DIM_W'(1);
      end else if (v > max_v) begin
         c = max_v;
      end else begin
         c = v;
      end
      return COL_W'(c - DIM_W'(1));
   endfunction

endpackage

@@ rtl/bmsw_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw channels
// Valid/ready interfaces for pixel requests and result responses.
// ----------------------------------------------------------------------------
interface bmsw_req_if;
   import bmsw_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bmsw_rsp_if;
   import bmsw_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_done;
   modport source (output valid, output pixel_out, output frame_done, input ready);
   modport sink   (input valid, input pixel_out, input frame_done, output ready);
endinterface

@@ rtl/binary_morphology_square_window_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_square_window_core
// Streaming binary erosion/dilation over a square window, line store in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | fields                  | handshake
//  req_ch  | in  | pixel_in[7:0]           | valid/ready
//  rsp_ch  | out | pixel_out[7:0], frame_done | valid/ready
//  csr_*   | in  | csr_index, csr_data     | csr_write_en, no back-pressure
//
//  One pixel per clock sustained while the pipeline is not stalled; a result
//  passes the line store read in the accept cycle, then the update and result register.
//  Column w==1 re-reads the entry being written: the write data is forwarded.
//  Synchronous reset loads config defaults and clears positions, column flags and valids.
//  The pipeline stalls only when a result is due while rsp holds an untaken one.
// ----------------------------------------------------------------------------
module binary_morphology_square_window_core
   import bmsw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   bmsw_req_if.sink              req_ch,
   bmsw_rsp_if.source            rsp_ch
);

   logic                mode_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic [DIM_W-1:0]    fwidth_ff;
   logic [DIM_W-1:0]    fheight_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                s1_valid_ff;
   stage_type           s1_ff, s1_in;
   logic                fwd_hit_ff;
   logic [STORE_W-1:0]  fwd_data_ff;
   logic [MAX_MASK-1:0] all_ff, all_in;
   logic [MAX_MASK-1:0] any_ff, any_in;
   logic                rsp_valid_ff;
   logic [PIX_W-1:0]    rsp_pix_ff;
   logic                rsp_done_ff;

   logic [MASK_W-1:0]   m_eff;
   logic [MASK_W-1:0]   m_m1;
   logic [COL_W-1:0]    w_last;
   logic [ROW_W-1:0]    h_last;
   logic                advance;
   logic                accept;
   logic                wr_en;
   logic [STORE_W-1:0]  ram_rdata;
   logic [STORE_W-1:0]  stored;
   logic [STORE_W-1:0]  store_wr;
   logic [STORE_W-1:0]  vmask;
   logic [MAX_MASK-1:0] wmask;
   logic                vall, vany, on;

   // effective configuration
   always_comb begin
      m_eff  = (mask_ff == '0) ? MASK_W'(1) : mask_ff;
      m_m1   = m_eff - MASK_W'(1);
      w_last = dim_last(fwidth_ff, DIM_W'(MAX_WIDTH));
      h_last = ROW_W'(dim_last(fheight_ff, DIM_W'(MAX_HEIGHT)));
      vmask  = STORE_W'(low_ones(m_m1));
      wmask  = low_ones(m_eff);
   end

   assign advance      = !(s1_valid_ff && s1_ff.emit && rsp_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;
   assign wr_en        = s1_valid_ff && advance;

   // accept stage: positions and line store read
   always_comb begin
      s1_in.fg   = (req_ch.pixel_in > FG_THRESHOLD);
      s1_in.emit = (row_ff >= ROW_W'(m_m1)) && (col_ff >= COL_W'(m_m1));
      s1_in.last = (row_ff == h_last) && (col_ff == w_last);
      s1_in.col  = col_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      if (col_ff == w_last) begin
         col_in = '0;
         row_in = (row_ff == h_last) ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
      end
   end

   bmsw_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (store_wr),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   // update stage: column run, flag shift, result
   always_comb begin
      stored   = fwd_hit_ff ? fwd_data_ff : ram_rdata;
      vall     = s1_ff.fg && ((stored & vmask) == vmask);
      vany     = s1_ff.fg || ((stored & vmask) != '0);
      store_wr = {stored[STORE_W-2:0], s1_ff.fg};
      all_in   = {all_ff[MAX_MASK-2:0], vall};
      any_in   = {any_ff[MAX_MASK-2:0], vany};
      on       = mode_ff ? ((any_in & wmask) != '0) : ((all_in & wmask) == wmask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         mask_ff      <= MASK_RESET;
         fwidth_ff    <= WIDTH_RESET;
         fheight_ff   <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         all_ff       <= '0;
         any_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MODE:         mode_ff    <= csr_data[0];
               CSR_MASK_SIZE:    mask_ff    <= csr_data[MASK_W-1:0];
               CSR_FRAME_WIDTH:  fwidth_ff  <= csr_data[DIM_W-1:0];
               CSR_FRAME_HEIGHT: fheight_ff <= csr_data[DIM_W-1:0];
               default: ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end else if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (advance) begin
            s1_valid_ff <= accept;
         end
         if (wr_en) begin
            all_ff <= all_in;
            any_ff <= any_in;
         end
         if (wr_en && s1_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         fwd_hit_ff  <= wr_en && (s1_ff.col == col_ff);
         fwd_data_ff <= store_wr;
      end
      if (wr_en && s1_ff.emit) begin
         rsp_pix_ff  <= on ? PIX_ON : PIX_OFF;
         rsp_done_ff <= s1_ff.last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_out  = rsp_pix_ff;
   assign rsp_ch.frame_done = rsp_done_ff;

endmodule

@@ rtl/bmsw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/tb_binary_morphology_square_window_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_morphology_square_window_core
// Self-checking bench for the streaming erosion/dilation core. A bit-level
// predictor tracks line store, column flags and frame position for every
// accepted pixel; each response transaction is checked in order against it.
// Directed frames cover both modes, threshold edges, frame wrap, zero and
// oversized settings; then maximum-size frames, randomised frames under
// random back-pressure, and an unpaced tail.
// ----------------------------------------------------------------------------
module tb_binary_morphology_square_window_core;
   import bmsw_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 250;
   localparam int PHASE_CAP     = 180;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_done;
   } window_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   bmsw_req_if req_ch ();
   bmsw_rsp_if rsp_ch ();

   binary_morphology_square_window_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch)
   );

   always #5 clock = ~clock;

   // predictor state
   logic                  cfg_mode;
   logic [MASK_W-1:0]     cfg_mask;
   logic [DIM_W-1:0]      cfg_width;
   logic [DIM_W-1:0]      cfg_height;
   logic [STORE_W-1:0]    column_history [MAX_WIDTH];
   logic [MAX_MASK-1:0]   run_all;
   logic [MAX_MASK-1:0]   run_any;
   int unsigned           col_at;
   int unsigned           row_at;

   window_result_type window_results_due [$];
   int                mismatch_count = 0;
   bit                idle_enable    = 1'b1;

   function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void advance_window(input logic [PIX_W-1:0] px);
      int unsigned         m, w, h, c, r;
      logic                fg, col_all, col_any, on;
      logic [STORE_W-1:0]  held, vbits;
      logic [MAX_MASK-1:0] wbits;
      window_result_type   res;
      m = bounded(cfg_mask, MAX_MASK);
      w = bounded(cfg_width, MAX_WIDTH);
      h = bounded(cfg_height, MAX_HEIGHT);
      c = (col_at >= w) ? 0 : col_at;
      r = (row_at >= h) ? 0 : row_at;
      fg    = (px > FG_THRESHOLD);
      held  = column_history[c];
      vbits = STORE_W'((1 << (m - 1)) - 1);
      wbits = MAX_MASK'((1 << m) - 1);
      col_all = fg && ((held & vbits) == vbits);
      col_any = fg || ((held & vbits) != '0);
      column_history[c] = {held[STORE_W-2:0], fg};
      run_all = {run_all[MAX_MASK-2:0], col_all};
      run_any = {run_any[MAX_MASK-2:0], col_any};
      if (r + 1 >= m && c + 1 >= m) begin
         on = cfg_mode ? ((run_any & wbits) != '0) : ((run_all & wbits) == wbits);
         res.pixel_out  = on ? PIX_ON : PIX_OFF;
         res.frame_done = (r + 1 == h) && (c + 1 == w);
         window_results_due.push_back(res);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_at = c;
      row_at = r;
   endfunction

   function automatic logic [PIX_W-1:0] draw_pixel(input int fg_pct);
      if ($urandom_range(0, 15) == 0) return PIX_W'($urandom_range(0, 255));
      if ($urandom_range(1, 100) <= fg_pct) return PIX_W'($urandom_range(128, 255));
      return PIX_W'($urandom_range(0, 127));
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] px);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pixel_in <= px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_window(px);
   endtask

   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      while (window_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      case (idx)
         CSR_MODE:         cfg_mode   = value[0];
         CSR_MASK_SIZE:    cfg_mask   = value[MASK_W-1:0];
         CSR_FRAME_WIDTH:  cfg_width  = value[DIM_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
         default: ;
      endcase
      col_at = 0;
      row_at = 0;
   endtask

   task automatic program_window(input logic [3:0] pick,
                                 input logic [CSR_DATA_W-1:0] mode_v,
                                 input logic [CSR_DATA_W-1:0] mask_v,
                                 input logic [CSR_DATA_W-1:0] width_v,
                                 input logic [CSR_DATA_W-1:0] height_v);
      settle_pipeline();
      if (pick[CSR_MODE])         write_reg(CSR_MODE, mode_v);
      if (pick[CSR_MASK_SIZE])    write_reg(CSR_MASK_SIZE, mask_v);
      if (pick[CSR_FRAME_WIDTH])  write_reg(CSR_FRAME_WIDTH, width_v);
      if (pick[CSR_FRAME_HEIGHT]) write_reg(CSR_FRAME_HEIGHT, height_v);
      csr_write_en <= 1'b0;
   endtask

   // threshold edges, both modes, frame wrap, zero settings, window > frame
   task automatic test_directed();
      logic [PIX_W-1:0] erode_px [18] = '{8'd255, 8'd200, 8'd128, 8'd255, 8'd255, 8'd255,
                                          8'd128, 8'd255, 8'd129, 8'd255, 8'd255, 8'd255,
                                          8'd255, 8'd127, 8'd255, 8'd255, 8'd255, 8'd255};
      logic [PIX_W-1:0] dilate_px [4] = '{8'd0, 8'd127, 8'd128, 8'd0};
      program_window(4'hF, 11'd0, 11'd3, 11'd3, 11'd3);
      foreach (erode_px[i]) send_pixel(erode_px[i]);
      program_window(4'hF, 11'd1, 11'd2, 11'd2, 11'd2);
      foreach (dilate_px[i]) send_pixel(dilate_px[i]);
      program_window(4'hE, 11'd1, 11'd0, 11'd0, 11'd0);
      send_pixel(8'd0);
      send_pixel(8'd255);
      program_window(4'hE, 11'd0, 11'd31, 11'd3, 11'd3);
      send_pixel(8'd255);
      send_pixel(8'd128);
   endtask

   task automatic test_largest_frames();
      program_window(4'hF, 11'd0, 11'd1, 11'd2047, 11'd1);
      repeat (MAX_WIDTH + 2) send_pixel(draw_pixel(50));
      program_window(4'hF, 11'd1, 11'd1, 11'd1, 11'd1024);
      repeat (40) send_pixel(draw_pixel(50));
   endtask

   task automatic test_random_frames();
      int                    sent;
      int                    fg_pct;
      int unsigned           count, w, h;
      logic [CSR_DATA_W-1:0] mode_v, mask_v, width_v, height_v;
      logic [3:0]            pick;
      sent = 0;
      pick = 4'hF;
      while (sent < RANDOM_ITEMS) begin
         mode_v = CSR_DATA_W'($urandom_range(0, 2047));
         mask_v = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(0, 15))
                                               : CSR_DATA_W'($urandom_range(1, 5));
         if ($urandom_range(0, 7) == 0)
            mask_v[CSR_DATA_W-1:MASK_W] = 7'($urandom_range(0, 127));
         case ($urandom_range(0, 9))
            0:       width_v = '0;
            1:       width_v = 11'd1;
            2:       width_v = CSR_DATA_W'($urandom_range(13, 40));
            3:       width_v = CSR_DATA_W'($urandom_range(1000, 2047));
            default: width_v = CSR_DATA_W'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       height_v = '0;
            1:       height_v = 11'd1;
            2:       height_v = CSR_DATA_W'($urandom_range(11, 20));
            3:       height_v = CSR_DATA_W'($urandom_range(1000, 2047));
            default: height_v = CSR_DATA_W'($urandom_range(2, 10));
         endcase
         program_window(pick, mode_v, mask_v, width_v, height_v);
         idle_enable = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0:       fg_pct = 0;
            1:       fg_pct = 25;
            2:       fg_pct = 50;
            3:       fg_pct = 75;
            4:       fg_pct = 90;
            default: fg_pct = 100;
         endcase
         w = bounded(cfg_width, MAX_WIDTH);
         h = bounded(cfg_height, MAX_HEIGHT);
         count = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
         if (count > PHASE_CAP) count = PHASE_CAP;
         if (count > unsigned'(RANDOM_ITEMS - sent)) count = unsigned'(RANDOM_ITEMS - sent);
         repeat (count) send_pixel(draw_pixel(fg_pct));
         sent += count;
         pick = 4'($urandom_range(0, 15));
      end
   endtask

   task automatic test_unpaced_tail();
      idle_enable = 1'b0;
      program_window(4'hF, 11'd0, 11'd2, 11'd6, 11'd5);
      repeat (60) send_pixel(draw_pixel(80));
      program_window(4'hF, 11'd1, 11'd4, 11'd7, 11'd7);
      repeat (49) send_pixel(draw_pixel(15));
      settle_pipeline();
   endtask

   // response back-pressure
   initial begin : rsp_pacing
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      window_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (window_results_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction, expected none, actual pixel_out=%0d frame_done=%0b",
                     $time, rsp_ch.pixel_out, rsp_ch.frame_done);
         end else begin
            want = window_results_due.pop_front();
            if (rsp_ch.pixel_out !== want.pixel_out) begin
               mismatch_count++;
               $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                        $time, want.pixel_out, rsp_ch.pixel_out);
            end
            if (rsp_ch.frame_done !== want.frame_done) begin
               mismatch_count++;
               $display("%0t: frame_done mismatch, expected %0b actual %0b",
                        $time, want.frame_done, rsp_ch.frame_done);
            end
         end
      end
   end

   initial begin : run_limit
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : main_sequence
      reset           <= 1'b1;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_MODE;
      csr_data        <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.pixel_in <= '0;
      cfg_mode   = 1'b0;
      cfg_mask   = MASK_RESET;
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      run_all    = '0;
      run_any    = '0;
      col_at     = 0;
      row_at     = 0;
      for (int i = 0; i < MAX_WIDTH; i++) column_history[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_largest_frames();
      test_random_frames();
      test_unpaced_tail();

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/bmsw_pkg.sv
rtl/bmsw_channels.sv
rtl/bmsw_ram.sv
rtl/binary_morphology_square_window_core.sv
tb/sv/tb_binary_morphology_square_window_core.sv
